@@ src/utf8_xml_escape_stream_defines.svh @@
// ----------------------------------------------------------------------------
// utf8_xml_escape_stream assertion macros
// Concurrent assertion shorthands used by the escape stream emitter (uxe_emit).
// ----------------------------------------------------------------------------
`ifndef UTF8_XML_ESCAPE_STREAM_DEFINES_SVH
`define UTF8_XML_ESCAPE_STREAM_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UXE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uxe assertion failed");

// next-cycle implication
`define UXE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uxe assertion failed");

`else

`define UXE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UXE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/uxe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uxe_pkg
// Types and constants shared by the UTF-8 to XML escape stream.
// ----------------------------------------------------------------------------
package uxe_pkg;

	localparam int CpW  = 21;
	localparam int LenW = 4;

	localparam logic [1:0] QM_APOS = 2'd1;
	localparam logic [1:0] QM_QUOT = 2'd2;

	// what one decoded code point turns into
	typedef enum logic [2:0] {
		TK_LIT,
		TK_AMP,
		TK_LT,
		TK_GT,
		TK_APOS,
		TK_QUOT,
		TK_HEX,
		TK_ERR
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t         kind;
		logic [CpW-1:0]    cp;
		logic [LenW-1:0]   len;   // output bytes for this token
		logic              done;  // token ends the string
	} tok_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'h0, n};
		end else begin
			return 8'h37 + {4'h0, n};
		end
	endfunction

endpackage

@@ src/uxe_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uxe_decode
// UTF-8 sequence decoder: gathers code points and classifies each one into
// an escape token for the emitter.
// ----------------------------------------------------------------------------
module uxe_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        quote_mode,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              tok_ready,
	output logic              tok_load,
	output uxe_pkg::tok_t     tok
);
	import uxe_pkg::*;

	logic [1:0]     pend_q, pend_n;
	logic [CpW-1:0] acc_q, acc_n;
	logic           disc_q, disc_n;
	logic           bad, have_cp;
	logic [CpW-1:0] cp, shifted;
	logic           accept;

	assign accept  = in_valid && tok_ready;
	assign shifted = {acc_q[CpW-7:0], in_byte[5:0]};

	always_comb begin
		pend_n  = pend_q;
		acc_n   = acc_q;
		disc_n  = disc_q;
		bad     = 1'b0;
		have_cp = 1'b0;
		cp      = '0;
		if (disc_q) begin
			if (in_last) begin
				disc_n = 1'b0;
			end
		end else begin
			priority if (pend_q != 2'd0) begin
				if (in_byte[7:6] != 2'b10) begin
					bad = 1'b1;
				end else begin
					acc_n  = shifted;
					pend_n = pend_q - 2'd1;
					if (pend_q == 2'd1) begin
						cp      = shifted;
						have_cp = 1'b1;
					end
				end
			end else if (!in_byte[7]) begin
				cp      = {{(CpW-8){1'b0}}, in_byte};
				have_cp = 1'b1;
			end else if (in_byte[7:5] == 3'b110) begin
				acc_n  = {{(CpW-5){1'b0}}, in_byte[4:0]};
				pend_n = 2'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				acc_n  = {{(CpW-4){1'b0}}, in_byte[3:0]};
				pend_n = 2'd2;
			end else if (in_byte[7:3] == 5'b11110) begin
				acc_n  = {{(CpW-3){1'b0}}, in_byte[2:0]};
				pend_n = 2'd3;
			end else begin
				bad = 1'b1;
			end
			// truncated sequence
			if (!bad && in_last && !have_cp) begin
				bad = 1'b1;
			end
			if (bad) begin
				pend_n = 2'd0;
				acc_n  = '0;
				disc_n = !in_last;
			end else if (have_cp) begin
				acc_n = '0;
			end
		end
	end

	// token classification
	always_comb begin
		tok.cp   = cp;
		tok.done = bad || in_last;
		tok.kind = TK_LIT;
		tok.len  = LenW'(1);
		priority if (bad) begin
			tok.kind = TK_ERR;
		end else if (cp == CpW'(8'h26)) begin
			tok.kind = TK_AMP;
			tok.len  = LenW'(5);
		end else if (cp == CpW'(8'h3C)) begin
			tok.kind = TK_LT;
			tok.len  = LenW'(4);
		end else if (cp == CpW'(8'h3E)) begin
			tok.kind = TK_GT;
			tok.len  = LenW'(4);
		end else if (quote_mode == QM_APOS && cp == CpW'(8'h27)) begin
			tok.kind = TK_APOS;
			tok.len  = LenW'(6);
		end else if (quote_mode == QM_QUOT && cp == CpW'(8'h22)) begin
			tok.kind = TK_QUOT;
			tok.len  = LenW'(6);
		end else if (cp == CpW'(8'h09) || cp == CpW'(8'h0A) || cp == CpW'(8'h0D)) begin
			tok.kind = TK_LIT;
		end else if (cp < CpW'(8'h20) || cp > CpW'(8'h7E)) begin
			tok.kind = TK_HEX;
			// "&#x" + digits + ";"
			priority if (cp < CpW'(24'h100)) begin
				tok.len = LenW'(6);
			end else if (cp < CpW'(24'h10000)) begin
				tok.len = LenW'(8);
			end else if (cp < CpW'(24'h100000)) begin
				tok.len = LenW'(9);
			end else begin
				tok.len = LenW'(10);
			end
		end else begin
			tok.kind = TK_LIT;
		end
	end

	assign tok_load = accept && !disc_q && (bad || have_cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			acc_q  <= '0;
			disc_q <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_n;
			acc_q  <= acc_n;
			disc_q <= disc_n;
		end
	end

endmodule

@@ src/uxe_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uxe_emit
// Token register and byte sequencer: spells out one token a byte per cycle
// into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`include "utf8_xml_escape_stream_defines.svh"

module uxe_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_load,
	input  uxe_pkg::tok_t     tok,
	output logic              tok_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_run_last,
	output logic              out_done,
	output logic              out_bad
);
	import uxe_pkg::*;

	tok_t            tok_s1;
	logic            tok_vld_s1;
	logic [LenW-1:0] idx_q;
	logic            advance, emit, fin;
	logic [7:0]      byte_c;
	logic [2:0]      nib_sel;
	logic [23:0]     cp_sh;
	logic            vld_s2;
	logic [7:0]      byte_s2;
	logic            run_s2, done_s2, bad_s2;

	assign advance   = !vld_s2 || out_ready;
	assign emit      = tok_vld_s1 && advance;
	assign fin       = emit && (idx_q == tok_s1.len - LenW'(1));
	assign tok_ready = !tok_vld_s1 || fin;

	// hex digits run from the most significant nibble down
	assign nib_sel = 3'(tok_s1.len - idx_q - LenW'(2));
	assign cp_sh   = {3'b000, tok_s1.cp} >> {nib_sel, 2'b00};

	always_comb begin
		byte_c = 8'h00;
		unique case (tok_s1.kind)
			TK_LIT: byte_c = tok_s1.cp[7:0];
			TK_ERR: byte_c = 8'h00;
			TK_AMP: begin
				unique case (idx_q)
					4'd0:    byte_c = "&";
					4'd1:    byte_c = "a";
					4'd2:    byte_c = "m";
					4'd3:    byte_c = "p";
					default: byte_c = ";";
				endcase
			end
			TK_LT: begin
				unique case (idx_q)
					4'd0:    byte_c = "&";
					4'd1:    byte_c = "l";
					4'd2:    byte_c = "t";
					default: byte_c = ";";
				endcase
			end
			TK_GT: begin
				unique case (idx_q)
					4'd0:    byte_c = "&";
					4'd1:    byte_c = "g";
					4'd2:    byte_c = "t";
					default: byte_c = ";";
				endcase
			end
			TK_APOS: begin
				unique case (idx_q)
					4'd0:    byte_c = "&";
					4'd1:    byte_c = "a";
					4'd2:    byte_c = "p";
					4'd3:    byte_c = "o";
					4'd4:    byte_c = "s";
					default: byte_c = ";";
				endcase
			end
			TK_QUOT: begin
				unique case (idx_q)
					4'd0:    byte_c = "&";
					4'd1:    byte_c = "q";
					4'd2:    byte_c = "u";
					4'd3:    byte_c = "o";
					4'd4:    byte_c = "t";
					default: byte_c = ";";
				endcase
			end
			TK_HEX: begin
				priority if (idx_q == 4'd0) begin
					byte_c = "&";
				end else if (idx_q == 4'd1) begin
					byte_c = "#";
				end else if (idx_q == 4'd2) begin
					byte_c = "x";
				end else if (idx_q == tok_s1.len - LenW'(1)) begin
					byte_c = ";";
				end else begin
					byte_c = hex_char(cp_sh[3:0]);
				end
			end
			default: byte_c = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_s1 <= 1'b0;
			idx_q      <= '0;
			vld_s2     <= 1'b0;
		end else begin
			if (tok_load) begin
				tok_vld_s1 <= 1'b1;
				idx_q      <= '0;
			end else if (fin) begin
				tok_vld_s1 <= 1'b0;
				idx_q      <= '0;
			end else if (emit) begin
				idx_q <= idx_q + LenW'(1);
			end
			if (advance) begin
				vld_s2 <= tok_vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_load) begin
			tok_s1 <= tok;
		end
		if (emit) begin
			byte_s2 <= byte_c;
			run_s2  <= fin;
			done_s2 <= fin && tok_s1.done;
			bad_s2  <= tok_s1.kind == TK_ERR;
		end
	end

	assign out_valid    = vld_s2;
	assign out_byte     = byte_s2;
	assign out_run_last = run_s2;
	assign out_done     = done_s2;
	assign out_bad      = bad_s2;

	`UXE_ASSERT_IMPL(a_idx_in_range, clk, arst_n, tok_vld_s1, idx_q < tok_s1.len)
	`UXE_ASSERT_IMPL(a_err_shape, clk, arst_n, vld_s2 && bad_s2,
		byte_s2 == 8'h00 && run_s2 && done_s2)
	`UXE_ASSERT_IMPL(a_done_ends_run, clk, arst_n, vld_s2 && done_s2, run_s2)
	`UXE_ASSERT_NEXT(a_slot_frees, clk, arst_n, fin && !tok_load, !tok_vld_s1)

endmodule

@@ src/utf8_xml_escape_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_xml_escape_stream
// UTF-8 byte stream in, XML-escaped byte stream out.
// ----------------------------------------------------------------------------
// Each input byte is decoded in the cycle it is accepted and, if it completes
// a code point or an error, becomes a token in the token register; the token
// is then spelled out one byte per cycle, unless the output stalls, into the
// output register. A new byte is taken every cycle unless the output stalls
// or an escape is still being spelled out; an escape holds the input until
// all its bytes are out: 4 for &lt; and &gt;, 5 for &amp;, 6 for &apos;,
// &quot; and two-digit hex escapes, up to 10 for six-digit hex escapes. The
// token register holds a single token. Malformed UTF-8 gives one result with
// tuser[1] set and the rest of the string is dropped up to tlast on the input.
// quote_mode must be written by the user only while the block is idle, which
// the block itself does not enforce; there is no clearing pass after reset.
module utf8_xml_escape_stream (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       quote_wr_en,
	input  logic [1:0] quote_wr_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] run_last, [1] bad_encoding
	output logic       m_axis_tlast    // string_done
);
	import uxe_pkg::*;

	logic [1:0] quote_mode_q;
	logic       tok_ready, tok_load;
	tok_t       tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_mode_q <= 2'd0;
		end else if (quote_wr_en) begin
			quote_mode_q <= quote_wr_data;
		end
	end

	assign s_axis_tready = tok_ready;

	uxe_decode u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.quote_mode (quote_mode_q),
		.in_valid   (s_axis_tvalid),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.tok_ready  (tok_ready),
		.tok_load   (tok_load),
		.tok        (tok)
	);

	uxe_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_load     (tok_load),
		.tok          (tok),
		.tok_ready    (tok_ready),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.out_run_last (m_axis_tuser[0]),
		.out_done     (m_axis_tlast),
		.out_bad      (m_axis_tuser[1])
	);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_xml_escape_stream. UTF-8 strings go in on the
// slave stream one byte per transaction. A behavioural decoder and escaper in
// the bench predicts every output byte with its flags, and each output
// transaction is checked in order. Directed strings come first, then random
// well-formed and broken strings under several quote modes and stall patterns.
// ----------------------------------------------------------------------------
module tb;
	import uxe_pkg::*;

	localparam logic [1:0] QM_NONE = 2'd0;
	localparam logic [1:0] QM_RSVD = 2'd3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int MAX_SHOWN     = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       done;
		logic       bad;
	} esc_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       quote_wr_en = 1'b0;
	logic [1:0] quote_wr_data = 2'd0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic [1:0] m_axis_tuser;           // [0] run_last, [1] bad_encoding
	logic       m_axis_tlast;

	// predictor state
	logic [1:0]  quote_sel = QM_NONE;
	logic [1:0]  pend_cnt = 2'd0;
	logic [20:0] cp_acc = '0;
	logic        drop_rest = 1'b0;
	esc_beat_t   escaped_q[$];
	logic [7:0]  esc_txt[$];
	string       hex_digits = "0123456789ABCDEF";

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	logic hold_tog = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;

	int fail_cnt = 0;
	int shown = 0;
	int n_bytes = 0;
	int live_bytes = 0;
	int n_checked = 0;
	int n_bad = 0;

	logic [7:0] ascii_edge [13] = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h1F, 8'h20, 8'h22,
		8'h26, 8'h27, 8'h3C, 8'h3E, 8'h7E, 8'h7F};

	utf8_xml_escape_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.quote_wr_en   (quote_wr_en),
		.quote_wr_data (quote_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_string();
		pend_cnt = 2'd0;
		cp_acc = '0;
		drop_rest = 1'b0;
	endfunction

	function automatic void spell(string s);
		for (int i = 0; i < s.len(); i++)
			esc_txt.push_back(s[i]);
	endfunction

	function automatic void escape_code_point(logic [20:0] cp);
		int nd;
		esc_txt.delete();
		if (cp == CH_AMP) begin
			spell("&amp;");
		end else if (cp == CH_LT) begin
			spell("&lt;");
		end else if (cp == CH_GT) begin
			spell("&gt;");
		end else if (quote_sel == QM_APOS && cp == CH_APOS) begin
			spell("&apos;");
		end else if (quote_sel == QM_QUOT && cp == CH_QUOT) begin
			spell("&quot;");
		end else if (cp == CH_TAB || cp == CH_LF || cp == CH_CR) begin
			esc_txt.push_back(cp[7:0]);
		end else if (cp < CH_SPACE || cp > CH_TILDE) begin
			if (cp < 21'h100)
				nd = 2;
			else if (cp < 21'h10000)
				nd = 4;
			else if (cp < 21'h100000)
				nd = 5;
			else
				nd = 6;
			spell("&#x");
			for (int i = nd - 1; i >= 0; i--)
				esc_txt.push_back(hex_digits[int'((cp >> (4 * i)) & 21'hF)]);
			esc_txt.push_back(CH_SEMI);
		end else begin
			esc_txt.push_back(cp[7:0]);
		end
	endfunction

	// one accepted input byte: decode and queue the escaped bytes it causes
	function automatic void predict_escape(logic [7:0] b, logic last);
		logic bad;
		logic have;
		logic [20:0] cp;
		bad = 1'b0;
		have = 1'b0;
		cp = '0;
		if (drop_rest) begin
			if (last)
				clear_string();
			return;
		end
		live_bytes++;
		if (pend_cnt != 2'd0) begin
			if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				pend_cnt = pend_cnt - 2'd1;
				if (pend_cnt == 2'd0) begin
					cp = cp_acc;
					have = 1'b1;
				end
			end
		end else if (b < 8'h80) begin
			cp = {13'd0, b};
			have = 1'b1;
		end else if (b >= 8'hC0 && b <= 8'hDF) begin
			cp_acc = {16'd0, b[4:0]};
			pend_cnt = 2'd1;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			cp_acc = {17'd0, b[3:0]};
			pend_cnt = 2'd2;
		end else if (b >= 8'hF0 && b <= 8'hF7) begin
			cp_acc = {18'd0, b[2:0]};
			pend_cnt = 2'd3;
		end else begin
			bad = 1'b1;
		end

		// string ends inside a sequence
		if (!bad && last && !have)
			bad = 1'b1;

		if (bad) begin
			escaped_q.push_back('{8'h00, 1'b1, 1'b1, 1'b1});
			clear_string();
			if (!last)
				drop_rest = 1'b1;
			return;
		end
		if (!have)
			return;

		cp_acc = '0;
		escape_code_point(cp);
		for (int i = 0; i < esc_txt.size(); i++)
			escaped_q.push_back('{esc_txt[i], i == esc_txt.size() - 1,
				last && (i == esc_txt.size() - 1), 1'b0});
		if (last)
			clear_string();
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (quote_wr_en)
				quote_sel = quote_wr_data;
			if (s_axis_tvalid && s_axis_tready) begin
				n_bytes++;
				predict_escape(s_axis_tdata, s_axis_tlast);
			end
		end
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		esc_beat_t got;
		esc_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
			if (escaped_q.size() == 0) begin
				fail_cnt++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("%0t: unexpected output byte %h run_last %b done %b bad %b",
						$time, got.ch, got.run_last, got.done, got.bad);
				end
			end else begin
				want = escaped_q.pop_front();
				n_checked++;
				if (want.bad)
					n_bad++;
				if (got.run_last !== want.run_last || got.done !== want.done ||
						got.bad !== want.bad || got.ch !== want.ch) begin
					fail_cnt++;
					if (shown < MAX_SHOWN) begin
						shown++;
						$display("%0t: mismatch exp byte %h rl %b done %b bad %b, got byte %h rl %b done %b bad %b",
							$time, want.ch, want.run_last, want.done, want.bad,
							got.ch, got.run_last, got.done, got.bad);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin
		if (hold_tog != hold_ack) begin
			hold_ack <= hold_tog;
			hold_left <= hold_len;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------- sender

	task automatic send_byte(logic [7:0] b, logic last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		for (int i = 0; i < seq.size(); i++)
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	task automatic wait_idle();
		int k;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		k = 0;
		while (escaped_q.size() != 0 && k < DRAIN_LIMIT) begin
			@(posedge clk);
			k++;
		end
		// bytes that cause no output may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quote(logic [1:0] mode);
		wait_idle();
		@(negedge clk);
		quote_wr_en <= 1'b1;
		quote_wr_data <= mode;
		@(negedge clk);
		quote_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	task automatic send_random_string();
		logic [7:0] seq[$];
		int n_cp;
		int pick;
		n_cp = $urandom_range(6, 1);
		for (int c = 0; c < n_cp; c++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				if ($urandom_range(1))
					seq.push_back(ascii_edge[$urandom_range(12)]);
				else
					seq.push_back({1'b0, 7'($urandom)});
			end else if (pick < 55) begin
				seq.push_back({3'b110, 5'($urandom)});
				seq.push_back(cont_byte());
			end else if (pick < 70) begin
				seq.push_back({4'b1110, 4'($urandom)});
				seq.push_back(cont_byte());
				seq.push_back(cont_byte());
			end else if (pick < 85) begin
				seq.push_back({5'b11110, 3'($urandom)});
				seq.push_back(cont_byte());
				seq.push_back(cont_byte());
				seq.push_back(cont_byte());
			end else if (pick < 92) begin
				seq.push_back(8'($urandom));
			end else begin
				// lead byte followed by something that is not a continuation
				seq.push_back({4'b1110, 4'($urandom)});
				if ($urandom_range(1))
					seq.push_back({1'b0, 7'($urandom)});
				else
					seq.push_back({2'b11, 6'($urandom)});
			end
		end
		// now and then the string stops in the middle of a sequence
		if ($urandom_range(9) == 0) begin
			seq.push_back({5'b11110, 3'($urandom)});
			repeat ($urandom_range(2))
				seq.push_back(cont_byte());
		end
		send_seq(seq);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_plain_ascii();
		logic [7:0] seq[$];
		idle_pct = 0;
		stall_pct = 0;
		write_quote(QM_NONE);
		seq = '{8'h00, 8'h26, 8'h3C, 8'h3E, 8'h0A, 8'h1F, 8'h7E, 8'h7F};
		send_seq(seq);
	endtask

	task automatic test_multibyte();
		logic [7:0] seq[$];
		// two-digit, four-digit and six-digit hex escapes
		seq = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
		send_seq(seq);
	endtask

	task automatic test_bad_utf8();
		logic [7:0] seq[$];
		// stray continuation as lead, rest of string dropped
		seq = '{8'hBF, 8'h41};
		send_seq(seq);
		// invalid lead on the final byte
		seq = '{8'hFF};
		send_seq(seq);
		// bad continuation
		seq = '{8'hC3, 8'h41};
		send_seq(seq);
		// truncated three-byte sequence
		seq = '{8'hE2, 8'h82};
		send_seq(seq);
	endtask

	task automatic test_quote_modes();
		logic [7:0] seq[$];
		seq = '{CH_APOS, CH_QUOT};
		write_quote(QM_APOS);
		send_seq(seq);
		write_quote(QM_QUOT);
		send_seq(seq);
		write_quote(QM_RSVD);
		send_seq(seq);
	endtask

	task automatic test_backpressure();
		logic [7:0] seq[$];
		idle_pct = 0;
		stall_pct = 0;
		wait_idle();
		hold_len = 300;
		hold_tog = ~hold_tog;
		for (int r = 0; r < 5; r++) begin
			seq.push_back(CH_AMP);
			seq.push_back(CH_LT);
			seq.push_back(8'h00);
			seq.push_back(8'hF4);
			seq.push_back(8'h8F);
			seq.push_back(8'hBF);
			seq.push_back(8'hBF);
		end
		send_seq(seq);
		wait_idle();
	endtask

	task automatic run_random(int idle, int stall, logic [1:0] mode, int n);
		int goal;
		write_quote(mode);
		idle_pct = idle;
		stall_pct = stall;
		goal = n_bytes + n;
		while (n_bytes < goal)
			send_random_string();
		wait_idle();
	endtask

	task automatic test_random();
		run_random(0, 0, QM_NONE, 90);
		run_random(78, 0, QM_APOS, 90);
		run_random(0, 78, QM_QUOT, 90);
		run_random(37, 37, QM_RSVD, 90);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_ascii();
		test_multibyte();
		test_bad_utf8();
		test_quote_modes();
		test_backpressure();
		test_random();

		wait_idle();
		if (escaped_q.size() != 0) begin
			fail_cnt += escaped_q.size();
			$display("%0d expected output bytes never arrived", escaped_q.size());
		end
		$display("sent %0d bytes (%0d decoded), checked %0d output bytes incl. %0d error results",
			n_bytes, live_bytes, n_checked, n_bad);
		$display("quote modes none, apos, quot and reserved; idle, stall and long hold-off");
		if (fail_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d failures", fail_cnt);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/uxe_pkg.sv
src/uxe_decode.sv
src/uxe_emit.sv
src/utf8_xml_escape_stream.sv
dv/tb.sv
